### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, clk, rstn, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and types of the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
  localparam int PAGE_BITS = 12;
  localparam int TOP_ORDER = 10;
  localparam int NORD      = TOP_ORDER + 1;
  localparam int PG_W      = PAGE_BITS;
  localparam int LNK_W     = PAGE_BITS + 1;
  localparam int ORD_W     = 4;
  localparam int OIDX_W    = $clog2(NORD);
  localparam int PM_W      = ORD_W + 1;

  localparam logic [LNK_W-1:0] NIL = LNK_W'(1) << PAGE_BITS;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic              set_head;
    logic [OIDX_W-1:0] idx;
    logic [LNK_W-1:0]  head_val;
  } lst_op_t;
endpackage
`default_nettype wire

### rtl/core/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over 2^PAGE_BITS pages with LIFO free lists per order.
//
// channel  dir  handshake               payload
// in_      in   in_valid / in_ready     action, req_order, page_index
// out_     out  out_valid / out_ready   status, block_page, block_order
//
// After reset a clearing pass writes every page table entry with in_ready
// low. An item then steps through search steps, an unlink, split pushes,
// merge checks and a final push, one state at a time, bounded by the single
// port of the page table and link memories. A result waits in the output
// register while the next transfer is taken; only a second finished result
// stalls on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module buddy_page_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [3:0]                 in_req_order,
  input  wire logic [11:0]                in_page_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [1:0]                 out_status,
  output logic      [11:0]                out_block_page,
  output logic      [3:0]                 out_block_order
);
  localparam int PG_W   = bpa_pkg::PG_W;
  localparam int LNK_W  = bpa_pkg::LNK_W;
  localparam int ORD_W  = bpa_pkg::ORD_W;
  localparam int OIDX_W = bpa_pkg::OIDX_W;
  localparam int PM_W   = bpa_pkg::PM_W;
  localparam logic [ORD_W-1:0] TOP = ORD_W'(bpa_pkg::TOP_ORDER);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SRCH  = 11'b00000000100,
    S_ULWR  = 11'b00000001000,
    S_SPLIT = 11'b00000010000,
    S_PUSH2 = 11'b00000100000,
    S_FCHK  = 11'b00001000000,
    S_MERGE = 11'b00010000000,
    S_MCHK  = 11'b00100000000,
    S_FINAL = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              act_r, act_nxt;
  logic [ORD_W-1:0]  want_r, want_nxt;
  logic [ORD_W-1:0]  o_r, o_nxt;
  logic [PG_W-1:0]   pg_r, pg_nxt;
  logic [PG_W-1:0]   b_r, b_nxt;
  logic [LNK_W-1:0]  h_r, h_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [PG_W-1:0]   clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [PG_W-1:0]   out_page_r, out_page_nxt;
  logic [ORD_W-1:0]  out_order_r, out_order_nxt;

  logic              pm_en, pm_we;
  logic [PG_W-1:0]   pm_addr;
  logic [PM_W-1:0]   pm_wd, pm_rd;
  logic              nx_en, nx_we, pv_en, pv_we;
  logic [PG_W-1:0]   nx_addr, pv_addr;
  logic [LNK_W-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;

  bpa_pkg::lst_op_t  lop;
  logic [OIDX_W-1:0] lst_idx, oi;
  logic [LNK_W-1:0]  lst_head, lst_cnt;
  logic [PG_W-1:0]   step, buddy;

  bpa_ram #(.W(PM_W), .AW(PG_W)) u_page_mem (
    .clk(clk), .en(pm_en), .we(pm_we), .addr(pm_addr), .wdata(pm_wd), .rdata(pm_rd)
  );
  bpa_ram #(.W(LNK_W), .AW(PG_W)) u_next_mem (
    .clk(clk), .en(nx_en), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd)
  );
  bpa_ram #(.W(LNK_W), .AW(PG_W)) u_prev_mem (
    .clk(clk), .en(pv_en), .we(pv_we), .addr(pv_addr), .wdata(pv_wd), .rdata(pv_rd)
  );
  bpa_lists u_lists (
    .clk(clk), .rst_n(rst_n), .rd_idx(lst_idx), .op(lop),
    .rd_head(lst_head), .rd_cnt(lst_cnt)
  );

  assign oi      = o_r[OIDX_W-1:0];
  assign lst_idx = (state_r == S_SPLIT) ? oi - 1'b1 : oi;
  assign step    = PG_W'(1) << o_r;
  assign buddy   = pg_r ^ step;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_page  = out_page_r;
  assign out_block_order = out_order_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    want_nxt       = want_r;
    o_nxt          = o_r;
    pg_nxt         = pg_r;
    b_nxt          = b_r;
    h_nxt          = h_r;
    stat_nxt       = stat_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_order_nxt  = out_order_r;
    pm_en = 1'b0; pm_we = 1'b0; pm_addr = pg_r; pm_wd = '0;
    nx_en = 1'b0; nx_we = 1'b0; nx_addr = pg_r; nx_wd = '0;
    pv_en = 1'b0; pv_we = 1'b0; pv_addr = pg_r; pv_wd = '0;
    lop = '{pop: 1'b0, push: 1'b0, set_head: 1'b0, idx: lst_idx, head_val: '0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        pm_en   = 1'b1;
        pm_we   = 1'b1;
        pm_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          want_nxt = in_req_order;
          o_nxt    = in_req_order;
          pg_nxt   = in_page_index[PG_W-1:0];
          stat_nxt = bpa_pkg::ST_OK;
          if (in_action == bpa_pkg::ACT_FREE) begin
            pm_en     = 1'b1;
            pm_addr   = in_page_index[PG_W-1:0];
            state_nxt = S_FCHK;
          end else if (in_req_order > TOP) begin
            stat_nxt  = bpa_pkg::ST_FAIL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lst_cnt != '0 && lst_head != bpa_pkg::NIL) begin
          pg_nxt    = lst_head[PG_W-1:0];
          b_nxt     = lst_head[PG_W-1:0];
          nx_en     = 1'b1;
          nx_addr   = lst_head[PG_W-1:0];
          pv_en     = 1'b1;
          pv_addr   = lst_head[PG_W-1:0];
          state_nxt = S_ULWR;
        end else if (o_r == TOP) begin
          stat_nxt  = bpa_pkg::ST_FAIL;
          state_nxt = S_DONE;
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      S_ULWR: begin
        if (pv_rd != bpa_pkg::NIL) begin
          nx_en   = 1'b1;
          nx_we   = 1'b1;
          nx_addr = pv_rd[PG_W-1:0];
          nx_wd   = nx_rd;
        end
        if (nx_rd != bpa_pkg::NIL) begin
          pv_en   = 1'b1;
          pv_we   = 1'b1;
          pv_addr = nx_rd[PG_W-1:0];
          pv_wd   = pv_rd;
        end
        lop.pop      = 1'b1;
        lop.set_head = (pv_rd == bpa_pkg::NIL);
        lop.head_val = nx_rd;
        if (act_r == bpa_pkg::ACT_FREE) begin
          pm_en     = 1'b1;
          pm_we     = 1'b1;
          pm_addr   = b_r;
          pm_wd     = {1'b0, o_r};
          pg_nxt    = (b_r < pg_r) ? b_r : pg_r;
          o_nxt     = o_r + 1'b1;
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (o_r > want_r) begin
          pm_en        = 1'b1;
          pm_we        = 1'b1;
          pm_wd        = {1'b1, o_r - 1'b1};
          nx_en        = 1'b1;
          nx_we        = 1'b1;
          nx_wd        = lst_head;
          pv_en        = 1'b1;
          pv_we        = 1'b1;
          pv_wd        = bpa_pkg::NIL;
          lop.push     = 1'b1;
          lop.head_val = {1'b0, pg_r};
          h_nxt        = lst_head;
          o_nxt        = o_r - 1'b1;
          state_nxt    = S_PUSH2;
        end else begin
          pm_en     = 1'b1;
          pm_we     = 1'b1;
          pm_wd     = {1'b0, want_r};
          state_nxt = S_DONE;
        end
      end
      S_PUSH2: begin
        if (h_r != bpa_pkg::NIL) begin
          pv_en   = 1'b1;
          pv_we   = 1'b1;
          pv_addr = h_r[PG_W-1:0];
          pv_wd   = {1'b0, pg_r};
        end
        if (act_r == bpa_pkg::ACT_FREE) begin
          state_nxt = S_DONE;
        end else begin
          pg_nxt    = pg_r + step;
          state_nxt = S_SPLIT;
        end
      end
      S_FCHK: begin
        if (pm_rd[PM_W-1]) begin
          stat_nxt  = bpa_pkg::ST_DUP;
          state_nxt = S_DONE;
        end else begin
          o_nxt     = (pm_rd[ORD_W-1:0] > TOP) ? TOP : pm_rd[ORD_W-1:0];
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (o_r < TOP && int'(o_r) < bpa_pkg::PAGE_BITS) begin
          b_nxt     = buddy;
          pm_en     = 1'b1;
          pm_addr   = buddy;
          state_nxt = S_MCHK;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_MCHK: begin
        if (pm_rd[PM_W-1] && pm_rd[ORD_W-1:0] == o_r) begin
          nx_en     = 1'b1;
          nx_addr   = b_r;
          pv_en     = 1'b1;
          pv_addr   = b_r;
          state_nxt = S_ULWR;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        pm_en        = 1'b1;
        pm_we        = 1'b1;
        pm_wd        = {1'b1, o_r};
        nx_en        = 1'b1;
        nx_we        = 1'b1;
        nx_wd        = lst_head;
        pv_en        = 1'b1;
        pv_we        = 1'b1;
        pv_wd        = bpa_pkg::NIL;
        lop.push     = 1'b1;
        lop.head_val = {1'b0, pg_r};
        h_nxt        = lst_head;
        state_nxt    = S_PUSH2;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_page_nxt   = (stat_r == bpa_pkg::ST_OK) ? pg_r : '0;
          out_order_nxt  = (stat_r == bpa_pkg::ST_OK) ? o_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    want_r       <= want_nxt;
    o_r          <= o_nxt;
    pg_r         <= pg_nxt;
    b_r          <= b_nxt;
    h_r          <= h_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_order_r  <= out_order_nxt;
  end

  `BPA_ASSERT(a_pop_nonempty, clk, rst_n, (state_r == S_ULWR) |-> (lst_cnt != '0), "unlink from empty list")
  `BPA_ASSERT(a_split_order, clk, rst_n, (state_r == S_SPLIT) |-> (o_r >= want_r), "split below requested order")
  `BPA_ASSERT(a_accept_leaves_idle, clk, rst_n, (in_valid && in_ready) |=> (state_r != S_IDLE), "transfer taken without work")
  `BPA_ASSERT(a_free_merge_bound, clk, rst_n, (state_r == S_FINAL) |-> (o_r <= TOP), "merged order above top order")
endmodule
`default_nettype wire

### rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_ram #(
  parameter int W  = 8,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [W-1:0]  wdata,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/bpa_lists.sv
// ----------------------------------------------------------------------------
// bpa_lists
// Per-order free list heads and counts.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_lists (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bpa_pkg::OIDX_W-1:0] rd_idx,
  input  wire bpa_pkg::lst_op_t           op,
  output logic      [bpa_pkg::LNK_W-1:0]  rd_head,
  output logic      [bpa_pkg::LNK_W-1:0]  rd_cnt
);
  logic [bpa_pkg::LNK_W-1:0] head_r [bpa_pkg::NORD];
  logic [bpa_pkg::LNK_W-1:0] cnt_r  [bpa_pkg::NORD];

  assign rd_head = head_r[rd_idx];
  assign rd_cnt  = cnt_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bpa_pkg::NORD; i++) begin
        head_r[i] <= bpa_pkg::NIL;
        cnt_r[i]  <= '0;
      end
    end else if (op.push) begin
      head_r[op.idx] <= op.head_val;
      cnt_r[op.idx]  <= cnt_r[op.idx] + 1'b1;
    end else if (op.pop) begin
      if (op.set_head) begin
        head_r[op.idx] <= op.head_val;
      end
      cnt_r[op.idx] <= cnt_r[op.idx] - 1'b1;
    end
  end
endmodule
`default_nettype wire

### test/buddy_page_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches the request and result channels, keeps its own copy of the page
// table and per-order free lists, predicts each response and compares it.
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_req_order,
  input  logic [11:0] in_page_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [11:0] out_block_page,
  input  logic [3:0]  out_block_order,
  output int          errors,
  output int          pending
);
  localparam int NPG = 1 << bpa_pkg::PAGE_BITS;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] page;
    logic [3:0]  order;
  } grant_t;

  logic                      pg_free [NPG];
  logic [3:0]                pg_ord  [NPG];
  logic [bpa_pkg::LNK_W-1:0] nxt     [NPG];
  logic [bpa_pkg::LNK_W-1:0] prv     [NPG];
  logic [bpa_pkg::LNK_W-1:0] head    [bpa_pkg::NORD];
  logic [12:0]               cnt     [bpa_pkg::NORD];
  grant_t                    grants[$];

  function automatic void push_blk(logic [11:0] pg, int o);
    logic [bpa_pkg::LNK_W-1:0] h;
    h = head[o];
    prv[pg] = bpa_pkg::NIL;
    nxt[pg] = h;
    if (h != bpa_pkg::NIL) prv[h[11:0]] = {1'b0, pg};
    head[o] = {1'b0, pg};
    cnt[o] = cnt[o] + 13'd1;
  endfunction

  function automatic void unlink_blk(logic [11:0] pg, int o);
    logic [bpa_pkg::LNK_W-1:0] p, n;
    p = prv[pg];
    n = nxt[pg];
    if (p == bpa_pkg::NIL) head[o] = n;
    else nxt[p[11:0]] = n;
    if (n != bpa_pkg::NIL) prv[n[11:0]] = p;
    cnt[o] = cnt[o] - 13'd1;
  endfunction

  function automatic grant_t serve(logic act, logic [3:0] want, logic [11:0] idx);
    grant_t g;
    int o;
    logic [11:0] pg, b;
    g = '0;
    if (act == bpa_pkg::ACT_ALLOC) begin
      if (want > bpa_pkg::TOP_ORDER) begin
        g.status = bpa_pkg::ST_FAIL;
        return g;
      end
      o = want;
      while (o <= bpa_pkg::TOP_ORDER && (cnt[o] == 0 || head[o] == bpa_pkg::NIL)) o++;
      if (o > bpa_pkg::TOP_ORDER) begin
        g.status = bpa_pkg::ST_FAIL;
        return g;
      end
      pg = head[o][11:0];
      unlink_blk(pg, o);
      pg_free[pg] = 1'b0;
      while (o > want) begin
        o--;
        pg_free[pg] = 1'b1;
        pg_ord[pg] = 4'(o);
        push_blk(pg, o);
        pg = pg + 12'(1 << o);
      end
      pg_free[pg] = 1'b0;
      pg_ord[pg] = want;
      g.status = bpa_pkg::ST_OK;
      g.page = pg;
      g.order = want;
    end else begin
      pg = idx;
      if (pg_free[pg]) begin
        g.status = bpa_pkg::ST_DUP;
        return g;
      end
      o = pg_ord[pg];
      if (o > bpa_pkg::TOP_ORDER) o = bpa_pkg::TOP_ORDER;
      while (o < bpa_pkg::TOP_ORDER) begin
        b = pg ^ 12'(1 << o);
        if (!pg_free[b] || pg_ord[b] != o) break;
        unlink_blk(b, o);
        pg_free[b] = 1'b0;
        if (b < pg) pg = b;
        o++;
      end
      pg_free[pg] = 1'b1;
      pg_ord[pg] = 4'(o);
      push_blk(pg, o);
      g.status = bpa_pkg::ST_OK;
      g.page = pg;
      g.order = 4'(o);
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t e;
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
      grants.delete();
      for (int i = 0; i < NPG; i++) begin
        pg_free[i] = 1'b0;
        pg_ord[i] = '0;
        nxt[i] = '0;
        prv[i] = '0;
      end
      for (int o = 0; o < bpa_pkg::NORD; o++) begin
        head[o] = bpa_pkg::NIL;
        cnt[o] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (grants.size() == 0) begin
          $display("%0t: unexpected result status=%0d page=%0d order=%0d", $time,
                   out_status, out_block_page, out_block_order);
          errors <= errors + 1;
        end else begin
          e = grants.pop_front();
          if (e.status != out_status || e.page != out_block_page ||
              e.order != out_block_order) begin
            $display("%0t: mismatch expected status=%0d page=%0d order=%0d, got %0d %0d %0d",
                     $time, e.status, e.page, e.order,
                     out_status, out_block_page, out_block_order);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        grants.push_back(serve(in_action, in_req_order, in_page_index));
      pending <= grants.size();
    end
  end
endmodule

### test/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator
// Fills part of the pool by freeing pages, then mixes allocates and frees of
// random pages with bad orders and double frees. A checker predicts every
// response; random stalls fall on both channels.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
  logic        clk, rst_n;
  logic        in_valid, in_ready, in_action;
  logic [3:0]  in_req_order;
  logic [11:0] in_page_index;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic [11:0] out_block_page;
  logic [3:0]  out_block_order;
  int          errors, pending;
  int          idle_cycles;
  bit          calm;

  buddy_page_allocator uut (.*);

  buddy_page_allocator_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= calm || ($urandom_range(99) >= 8);

  task automatic send(logic act, logic [3:0] ord, logic [11:0] pg);
    while (!calm && $urandom_range(99) < 8) @(negedge clk);
    in_valid = 1'b1;
    in_action = act;
    in_req_order = ord;
    in_page_index = pg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_req_order = '0;
    in_page_index = '0;
    out_ready = 1'b1;
    calm = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // directed: empty pool, bad order, fill, double free, extremes
    send(bpa_pkg::ACT_ALLOC, 4'd0, 12'hFFF);
    send(bpa_pkg::ACT_ALLOC, 4'd15, 12'h000);
    send(bpa_pkg::ACT_ALLOC, 4'd11, 12'h000);
    for (int i = 0; i < 1024; i++) send(bpa_pkg::ACT_FREE, 4'($urandom), 12'(i));
    send(bpa_pkg::ACT_FREE, 4'd0, 12'h000);
    send(bpa_pkg::ACT_FREE, 4'd0, 12'h400);
    send(bpa_pkg::ACT_ALLOC, 4'd10, 12'hFFF);
    send(bpa_pkg::ACT_ALLOC, 4'd0, 12'h000);
    send(bpa_pkg::ACT_ALLOC, 4'd5, 12'hABC);
    send(bpa_pkg::ACT_FREE, 4'd15, 12'h800);
    send(bpa_pkg::ACT_FREE, 4'd15, 12'hFFF);
    // random: frees hit any page, free or not
    for (int i = 0; i < 560; i++) begin
      calm = (i >= 200 && i < 400);
      r = $urandom_range(99);
      if (r < 50) send(bpa_pkg::ACT_ALLOC,
                       (r < 3) ? 4'($urandom_range(11, 15))
                               : 4'($urandom_range(0, 10) >> $urandom_range(0, 3)),
                       12'($urandom));
      else if (r < 95) send(bpa_pkg::ACT_FREE, 4'($urandom), 12'($urandom));
      else send(bpa_pkg::ACT_FREE, 4'($urandom), 12'($urandom_range(0, 4095) & 12'hFF0));
    end
    calm = 1'b1;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
